[src/sptw_pkg.sv]
// Shared types and constants for the Sv39 page table walker.
// No dependencies; imported by the top level.
package sptw_pkg;

  localparam int PPN_W   = 44;
  localparam int ENTRY_W = 54;
  localparam int VA_W    = 39;
  localparam int PA_W    = 56;
  localparam int FLAG_W  = 10;
  localparam int IDX_W   = 9;
  localparam int OFS_W   = 12;
  localparam int STAT_W  = 2;

  localparam logic [PPN_W-1:0] POOL_BASE_RST = 44'd524288;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_MISALIGNED = 2'd1,
    ST_NO_FRAME   = 2'd2,
    ST_NOT_MAPPED = 2'd3
  } status_t;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_MAP       = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK
  } state_t;

  // walk level encoding
  localparam logic [1:0] LVL_ROOT = 2'd2;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_LEAF = 2'd0;

endpackage

[src/sv39_page_table_walker.sv]
// Sv39 page table walker: top level, sequencer and table store.
// Depends on sptw_pkg and sptw_ram.
// Sequence: a full walk goes from S_IDLE through S_READ and S_CHECK once per level,
// then registers its result; a misaligned map goes from S_IDLE to S_CHECK; early failures finish sooner.
// Items are taken only in S_IDLE, so a new item waits until the last result is loaded;
// the walk is paced by the single store port (up to three dependent reads per item).
// Reset: synchronous; afterwards the store is swept to zero, one entry per
// cycle over all NUM_FRAMES*512 entries, and no input is taken until the sweep ends.
module sv39_page_table_walker
  import sptw_pkg::*;
#(
  parameter int NUM_FRAMES = 16
) (
  input  logic          clk,
  input  logic          rst,
  // configuration: pool_base_ppn
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [43:0]   cfg_data,
  // input items
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [111:0]  s_tdata,   // vaddr[38:0], paddr[94:39], pte_flags[104:95], zero pad
  input  logic          s_tuser,   // opcode
  // results
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [55:0]   m_tdata,   // phys_out[55:0]
  output logic [1:0]    m_tuser    // status[1:0]
);

  localparam int FW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int NFW   = FW + 1;
  localparam int DEPTH = NUM_FRAMES * (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0]    CLR_LAST = AW'(DEPTH - 1);
  localparam logic [NFW-1:0]   NF_N     = NFW'(NUM_FRAMES);
  localparam logic [PPN_W-1:0] NF_PPN   = PPN_W'(NUM_FRAMES);

  state_t state, state_next;

  logic [PPN_W-1:0]  pool_base;
  logic [1:0]        level, level_next;
  logic [FW-1:0]     frame, frame_next;
  logic [NFW-1:0]    nff, nff_next;
  logic [AW-1:0]     clr, clr_next;
  logic              misal, misal_next;

  opcode_t           op;
  logic [VA_W-1:0]   va;
  logic [PA_W-1:0]   pa;
  logic [FLAG_W-1:0] flags;
  logic              ld_in;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic              res_load;
  status_t           res_status;
  logic [PA_W-1:0]   res_phys;

  logic [IDX_W-1:0]  idx;
  logic [AW-1:0]     walk_addr;
  logic              ent_v;
  logic [PPN_W-1:0]  ent_ppn, rel, alloc_ppn;
  logic              rel_out, pool_empty, out_free, in_misal;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= POOL_BASE_RST;
    end else if (cfg_valid) begin
      pool_base <= cfg_data;
    end
  end

  always_comb begin
    case (level)
      LVL_ROOT: idx = va[38:30];
      LVL_MID:  idx = va[29:21];
      default:  idx = va[20:12];
    endcase
  end

  assign walk_addr  = {frame, idx};
  assign ent_v      = ram_rdata[0];
  assign ent_ppn    = ram_rdata[ENTRY_W-1:FLAG_W];
  assign rel        = ent_ppn - pool_base;
  assign rel_out    = (rel >= NF_PPN);
  assign alloc_ppn  = pool_base + PPN_W'(nff);
  assign pool_empty = (nff >= NF_N);
  assign out_free   = !m_tvalid || m_tready;
  assign in_misal   = (s_tuser == OP_MAP) &&
                      ((|s_tdata[OFS_W-1:0]) || (|s_tdata[VA_W+OFS_W-1:VA_W]));

  sptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    level_next = level;
    frame_next = frame;
    nff_next   = nff;
    clr_next   = clr;
    misal_next = misal;
    ld_in      = 1'b0;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = walk_addr;
    ram_wdata  = '0;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_phys   = '0;
    unique case (state)
      S_CLEAR: begin
        ram_addr = clr;
        ram_we   = 1'b1;
        clr_next = clr + 1'b1;
        if (clr == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ld_in      = 1'b1;
          level_next = LVL_ROOT;
          frame_next = '0;
          misal_next = in_misal;
          state_next = in_misal ? S_CHECK : S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (misal) begin
          if (out_free) begin
            res_load   = 1'b1;
            res_status = ST_MISALIGNED;
            state_next = S_IDLE;
          end
        end else if (level != LVL_LEAF) begin
          if (ent_v) begin
            if (rel_out) begin
              // pointer left the pool, e.g. after a base change
              if (out_free) begin
                res_load   = 1'b1;
                res_status = ST_NOT_MAPPED;
                state_next = S_IDLE;
              end
            end else begin
              frame_next = rel[FW-1:0];
              level_next = level - 1'b1;
              state_next = S_READ;
            end
          end else if (op == OP_TRANSLATE) begin
            if (out_free) begin
              res_load   = 1'b1;
              res_status = ST_NOT_MAPPED;
              state_next = S_IDLE;
            end
          end else if (pool_empty) begin
            if (out_free) begin
              res_load   = 1'b1;
              res_status = ST_NO_FRAME;
              state_next = S_IDLE;
            end
          end else begin
            // fresh frames are still zero from the sweep
            ram_we     = 1'b1;
            ram_wdata  = {alloc_ppn, {(FLAG_W-1){1'b0}}, 1'b1};
            frame_next = nff[FW-1:0];
            nff_next   = nff + 1'b1;
            level_next = level - 1'b1;
            state_next = S_READ;
          end
        end else if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          if (op == OP_MAP) begin
            ram_we     = 1'b1;
            ram_wdata  = {pa[PA_W-1:OFS_W], flags[FLAG_W-1:1], 1'b1};
            res_status = ST_OK;
          end else if (ent_v) begin
            res_status = ST_OK;
            res_phys   = {ent_ppn, va[OFS_W-1:0]};
          end else begin
            res_status = ST_NOT_MAPPED;
          end
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      nff      <= NFW'(1);
      level    <= LVL_ROOT;
      frame    <= '0;
      misal    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      nff   <= nff_next;
      level <= level_next;
      frame <= frame_next;
      misal <= misal_next;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_in) begin
      op    <= opcode_t'(s_tuser);
      va    <= s_tdata[VA_W-1:0];
      pa    <= s_tdata[VA_W+PA_W-1:VA_W];
      flags <= s_tdata[VA_W+PA_W+FLAG_W-1:VA_W+PA_W];
    end
    if (res_load) begin
      m_tuser <= res_status;
      m_tdata <= res_phys;
    end
  end

  // store is written only by the sweep or by the walk check cycle
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_CHECK))
    else $error("store write outside sweep or check");

  // frame counter never runs past the pool size
  a_nff_bound: assert property (@(posedge clk) disable iff (rst)
    nff <= NF_N)
    else $error("free frame counter overflow");

  // frame counter steps by one at most
  a_nff_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && nff != $past(nff)) |-> nff == $past(nff) + 1'b1)
    else $error("free frame counter jumped");

  // a result is only produced when the output register can take it
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result overwrote a pending transaction");

endmodule

[src/sptw_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module sptw_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
